>>> hdl/ssld_pkg.sv
// ----------------------------------------------------------------------------
// ssld_pkg
// Shared types and constants of the segmented sprite line decoder.
// ----------------------------------------------------------------------------
package ssld_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 12;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImgWidth  = 3'd0,
    CfgImgHeight = 3'd1,
    CfgFirstLine = 3'd2,
    CfgClipXLo   = 3'd3,
    CfgClipXHi   = 3'd4,
    CfgClipYLo   = 3'd5,
    CfgClipYHi   = 3'd6,
    CfgFlipMode  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] img_width;
    logic [11:0] img_height;
    logic [11:0] first_line;
    logic [11:0] clip_x_lo;
    logic [11:0] clip_x_hi;
    logic [11:0] clip_y_lo;
    logic [11:0] clip_y_hi;
    logic [1:0]  flip_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [15:0] color;
    logic [7:0]  alpha;
    logic        image_done;
    logic        overflow;
  } out_item_t;

  // Front-to-back command: one candidate pixel, a segment header or an end-of-image marker.
  typedef struct packed {
    logic              pix;       // candidate pixel
    logic              from_buf;  // color comes from the segment buffer
    logic [12:0]       col;       // unsigned column before flip and clipping
    logic [11:0]       row_out;   // row minus clip_y_lo
    logic [15:0]       color;
    logic [7:0]        alpha;
    logic [11:0]       buf_idx;
    logic [15:0]       seg_id;    // row stop scope
    logic              last;
    logic              overflow;
  } cmd_t;

  localparam logic [7:0]  AlphaOpaque = 8'd255;

endpackage

>>> hdl/ssld_if.sv
// ----------------------------------------------------------------------------
// ssld_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface ssld_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/ssld_front.sv
// ----------------------------------------------------------------------------
// ssld_front
// Parses the segment stream, tracks rows and buffers alpha-segment pixels.
// ----------------------------------------------------------------------------
module ssld_front #(
  parameter int unsigned SegBufDepth = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssld_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  input  ssld_pkg::in_item_t in_item_i,
  output logic              in_ready_o,
  output logic              cmd_valid_o,
  output ssld_pkg::cmd_t    cmd_o,
  input  logic              cmd_ready_i,
  output logic              wr_en_o,
  output logic [$clog2(SegBufDepth)-1:0] wr_addr_o,
  output logic [15:0]       wr_data_o
);
  localparam int unsigned AddrW = $clog2(SegBufDepth);

  logic [31:0] hdr_q, hdr_d;
  logic [17:0] pos_q, pos_d;
  logic [12:0] line_q, line_d;
  logic [7:0]  low_q, low_d;
  logic        vis_q, vis_d, istop_q, istop_d, first_q, first_d, ovf_q, ovf_d;
  logic [11:0] rowo_q, rowo_d;
  logic [15:0] seg_q, seg_d;
  logic [15:0] k_q, k_d;       // pixel/alpha index within segment
  logic        phase_q, phase_d; // 0 pixel bytes, 1 alpha bytes
  logic [17:0] rem_q, rem_d;   // bytes left in segment after header

  logic        acc;
  logic [7:0]  b;
  logic [31:0] hdr_full;
  logic        keep, has_a;
  logic [15:0] wdt;
  logic [12:0] ln0, ln1;
  logic signed [13:0] r;
  logic        in_hdr, last_seg_byte;
  ssld_pkg::cmd_t c;
  logic        emit;

  assign in_ready_o = cmd_ready_i;
  assign acc = in_valid_i & in_ready_o;
  assign b = in_item_i.data_byte;
  assign in_hdr = (pos_q < 18'd4);
  assign hdr_full = {b, hdr_q[23:0]};
  assign keep = hdr_full[14];
  assign has_a = hdr_full[15];
  assign wdt = hdr_full[31:16];

  always_comb begin
    hdr_d = hdr_q; pos_d = pos_q; line_d = line_q; low_d = low_q;
    vis_d = vis_q; istop_d = istop_q; first_d = first_q; ovf_d = ovf_q;
    rowo_d = rowo_q; seg_d = seg_q; k_d = k_q; phase_d = phase_q; rem_d = rem_q;
    ln0 = line_q; ln1 = line_q; r = '0;
    c = '0; emit = 1'b0; last_seg_byte = 1'b0;
    wr_en_o = 1'b0; wr_addr_o = k_q[AddrW-1:0]; wr_data_o = {b, low_q};
    if (in_hdr) begin
      hdr_d = hdr_q | (32'(b) << {pos_q[1:0], 3'b000});
      pos_d = pos_q + 18'd1;
      if (pos_q == 18'd3) begin
        ln0 = first_q ? (keep ? {1'b0, cfg_i.first_line} : 13'h1FFF) : line_q;
        ln1 = keep ? ln0 : ln0 + 13'd1;
        line_d = ln1; first_d = 1'b0;
        vis_d = 1'b0; seg_d = seg_q + 16'd1;
        k_d = '0; phase_d = 1'b0; low_d = low_q;
        rem_d = (has_a ? 18'(wdt) * 18'd3 : {1'b0, wdt, 1'b0}) + 18'(hdr_full[13:12]);
        if (has_a && wdt > 16'(SegBufDepth)) ovf_d = 1'b1;
        if (cfg_i.flip_mode[1]) r = 14'({2'b00, cfg_i.img_height}) - $signed({ln1[12], ln1}) - 14'sd1;
        else r = $signed({ln1[12], ln1});
        rowo_d = r[11:0] - cfg_i.clip_y_lo;
        if (!istop_q) begin
          if (cfg_i.flip_mode[1]) begin
            if (r > $signed({2'b00, cfg_i.clip_y_hi})) vis_d = 1'b0;
            else if (r < $signed({2'b00, cfg_i.clip_y_lo})) istop_d = 1'b1;
            else vis_d = 1'b1;
          end else begin
            if (r < $signed({2'b00, cfg_i.clip_y_lo})) vis_d = 1'b0;
            else if (r > $signed({2'b00, cfg_i.clip_y_hi})) istop_d = 1'b1;
            else vis_d = 1'b1;
          end
        end
        if (rem_d == 18'd0) begin
          last_seg_byte = 1'b1;
        end
      end
    end else begin
      rem_d = rem_q - 18'd1;
      if (rem_q == 18'd1) last_seg_byte = 1'b1;
      if (!phase_q && k_q < hdr_q[31:16]) begin
        if (!pos_q[0]) low_d = b;
        else begin
          if (hdr_q[15]) begin
            wr_en_o = k_q < 16'(SegBufDepth);
          end else begin
            c.pix = vis_q & ~istop_q; c.from_buf = 1'b0;
            c.color = {b, low_q}; c.alpha = ssld_pkg::AlphaOpaque;
          end
          c.col = 13'(hdr_q[11:0]) + k_q[12:0];
          if (k_q + 16'd1 == hdr_q[31:16]) begin
            k_d = '0; phase_d = 1'b1;
          end else k_d = k_q + 16'd1;
        end
        pos_d = pos_q + 18'd1;
      end else if (hdr_q[15] && k_q < hdr_q[31:16]) begin
        c.pix = vis_q & ~istop_q & (k_q < 16'(SegBufDepth));
        c.from_buf = 1'b1; c.alpha = b;
        c.col = 13'(hdr_q[11:0]) + k_q[12:0];
        k_d = k_q + 16'd1;
      end else begin
        k_d = hdr_q[31:16];
        phase_d = 1'b1;
      end
    end
    c.buf_idx = 12'(k_q[AddrW-1:0]);
    c.row_out = rowo_d;
    c.seg_id = seg_d;
    c.last = in_item_i.last_byte;
    c.overflow = ovf_d;
    // header command opens the row stop scope of the new segment
    emit = c.pix | c.last | (in_hdr && pos_q == 18'd3);
    if (last_seg_byte) begin
      pos_d = '0; hdr_d = '0;
    end
    if (in_item_i.last_byte) begin
      hdr_d = '0; pos_d = '0; line_d = '0; low_d = '0; vis_d = 1'b0;
      istop_d = 1'b0; first_d = 1'b1; ovf_d = 1'b0; seg_d = seg_q + 16'd1;
    end
    if (!acc) wr_en_o = 1'b0;
    cmd_valid_o = acc & emit;
    cmd_o = c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= '0; pos_q <= '0; line_q <= '0; low_q <= '0;
      vis_q <= 1'b0; istop_q <= 1'b0; first_q <= 1'b1; ovf_q <= 1'b0;
      rowo_q <= '0; seg_q <= '0; k_q <= '0; phase_q <= 1'b0; rem_q <= '0;
    end else if (acc) begin
      hdr_q <= hdr_d; pos_q <= pos_d; line_q <= line_d; low_q <= low_d;
      vis_q <= vis_d; istop_q <= istop_d; first_q <= first_d; ovf_q <= ovf_d;
      rowo_q <= rowo_d; seg_q <= seg_d; k_q <= k_d; phase_q <= phase_d; rem_q <= rem_d;
    end
  end
endmodule

>>> hdl/ssld_back.sv
// ----------------------------------------------------------------------------
// ssld_back
// Segment buffer, column clipping and the output register.
// ----------------------------------------------------------------------------
module ssld_back #(
  parameter int unsigned SegBufDepth = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssld_pkg::cfg_t    cfg_i,
  input  logic              cmd_valid_i,
  input  ssld_pkg::cmd_t    cmd_i,
  output logic              cmd_ready_o,
  input  logic              wr_en_i,
  input  logic [$clog2(SegBufDepth)-1:0] wr_addr_i,
  input  logic [15:0]       wr_data_i,
  output logic              out_valid_o,
  output ssld_pkg::out_item_t out_item_o,
  input  logic              out_ready_i
);
  localparam int unsigned AddrW = $clog2(SegBufDepth);

  logic [15:0] mem_q [SegBufDepth];
  logic [15:0] rd_q;

  // stage 1: command with buffer read
  logic           s1_v_q;
  ssld_pkg::cmd_t s1_q;
  logic           s1_go;

  // row stop, tracked at stage 1 in order
  logic        rstop_q;
  logic [15:0] rseg_q;
  logic        out_v_q;
  ssld_pkg::out_item_t out_q;

  logic signed [13:0] cc;
  logic        stopped, hit, stop_now;
  ssld_pkg::out_item_t o;

  assign cmd_ready_o = !s1_v_q || s1_go;
  assign s1_go = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
    if (cmd_valid_i && cmd_ready_o) rd_q <= mem_q[cmd_i.buf_idx[AddrW-1:0]];
  end

  always_comb begin
    stopped = rstop_q && (rseg_q == s1_q.seg_id);
    cc = cfg_i.flip_mode[0] ? 14'(cfg_i.img_width) - $signed({1'b0, s1_q.col})
                            : $signed({1'b0, s1_q.col});
    hit = 1'b0; stop_now = 1'b0;
    if (s1_q.pix && !stopped) begin
      if (cfg_i.flip_mode[0]) begin
        if (cc > $signed({2'b00, cfg_i.clip_x_hi})) hit = 1'b0;
        else if (cc < $signed({2'b00, cfg_i.clip_x_lo})) stop_now = 1'b1;
        else hit = 1'b1;
      end else begin
        if (cc < $signed({2'b00, cfg_i.clip_x_lo})) hit = 1'b0;
        else if (cc > $signed({2'b00, cfg_i.clip_x_hi})) stop_now = 1'b1;
        else hit = 1'b1;
      end
    end
    o = '0;
    o.pixel_valid = hit;
    if (hit) begin
      o.pixel_x = cc[11:0] - cfg_i.clip_x_lo;
      o.pixel_y = s1_q.row_out;
      o.color = s1_q.from_buf ? rd_q : s1_q.color;
      o.alpha = s1_q.alpha;
    end
    o.image_done = s1_q.last;
    o.overflow = s1_q.overflow;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0; out_v_q <= 1'b0; rstop_q <= 1'b0; rseg_q <= '0;
    end else begin
      if (s1_v_q && s1_go) begin
        if (stop_now) begin
          rstop_q <= 1'b1; rseg_q <= s1_q.seg_id;
        end else if (s1_q.seg_id != rseg_q) begin
          rstop_q <= 1'b0;
        end
      end
      if (cmd_ready_o) s1_v_q <= cmd_valid_i;
      if (s1_go) out_v_q <= s1_v_q && (hit || s1_q.last);
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) s1_q <= cmd_i;
    if (s1_go && s1_v_q) out_q <= o;
  end

  assign out_valid_o = out_v_q;
  assign out_item_o = out_q;
endmodule

>>> hdl/segmented_sprite_line_decoder.sv
// ----------------------------------------------------------------------------
// segmented_sprite_line_decoder
// Decodes a segmented sprite byte stream into clipped pixel writes.
// ----------------------------------------------------------------------------
// channel   dir  payload                                   request
// in_ch     in   data_byte, last_byte                      one stream byte
// out_ch    out  pixel_valid..overflow                     one pixel or done
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i            register write
// One byte per cycle unless output stalls; requests pass stage 1, then the output register.
// Buffer read and column clip are one stage after the parser.
// Reset clears parser state; the segment buffer is not cleared.
// A stalled output holds the back stage, which stops byte intake.
// ----------------------------------------------------------------------------
module segmented_sprite_line_decoder #(
  parameter int unsigned SEG_BUF_DEPTH = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [ssld_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ssld_pkg::CfgDataW-1:0] cfg_data_i,
  ssld_stream_if.sink   in_ch,
  ssld_stream_if.source out_ch
);
  ssld_pkg::cfg_t cfg_q;
  logic cmd_valid, cmd_ready, wr_en;
  ssld_pkg::cmd_t cmd;
  logic [$clog2(SEG_BUF_DEPTH)-1:0] wr_addr;
  logic [15:0] wr_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{img_width: 12'd0, img_height: 12'd0, first_line: 12'd0,
                 clip_x_lo: 12'd0, clip_x_hi: 12'hFFF, clip_y_lo: 12'd0,
                 clip_y_hi: 12'hFFF, flip_mode: 2'd0};
    end else if (cfg_we_i) begin
      unique case (ssld_pkg::cfg_idx_e'(cfg_idx_i))
        ssld_pkg::CfgImgWidth:  cfg_q.img_width <= cfg_data_i;
        ssld_pkg::CfgImgHeight: cfg_q.img_height <= cfg_data_i;
        ssld_pkg::CfgFirstLine: cfg_q.first_line <= cfg_data_i;
        ssld_pkg::CfgClipXLo:   cfg_q.clip_x_lo <= cfg_data_i;
        ssld_pkg::CfgClipXHi:   cfg_q.clip_x_hi <= cfg_data_i;
        ssld_pkg::CfgClipYLo:   cfg_q.clip_y_lo <= cfg_data_i;
        ssld_pkg::CfgClipYHi:   cfg_q.clip_y_hi <= cfg_data_i;
        ssld_pkg::CfgFlipMode:  cfg_q.flip_mode <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  ssld_front #(.SegBufDepth(SEG_BUF_DEPTH)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i(in_ch.valid), .in_item_i(in_ch.payload), .in_ready_o(in_ch.ready),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_ready_i(cmd_ready),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data)
  );

  ssld_back #(.SegBufDepth(SEG_BUF_DEPTH)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_ready_o(cmd_ready),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data),
    .out_valid_o(out_ch.valid), .out_item_o(out_ch.payload), .out_ready_i(out_ch.ready)
  );
endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the segmented sprite line decoder. A byte-level
// predictor tracks segment parsing, row and column clipping, flips and the
// alpha buffer; each pixel or end-of-image request is checked field by field
// against the oldest prediction. Directed images first, then random images
// under several register settings, with bursty idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int BufDepth = 1024;
  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 12;
  localparam int ItemTarget = 1500;
  localparam int IdleStop = 1300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ssld_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [ssld_pkg::CfgDataW-1:0] cfg_data_i = '0;

  ssld_stream_if #(.payload_t(ssld_pkg::in_item_t)) in_if ();
  ssld_stream_if #(.payload_t(ssld_pkg::out_item_t)) out_if ();

  segmented_sprite_line_decoder #(.SEG_BUF_DEPTH(BufDepth)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_ch(in_if),
    .out_ch(out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  ssld_pkg::cfg_t regs;
  logic [31:0] hdr;
  int          byte_pos;
  logic [12:0] line_cnt;
  logic [7:0]  low_hold;
  logic [15:0] seg_buf [BufDepth];
  bit          seg_vis, row_stop, img_stop, first_seg, ovf_seen;

  ssld_pkg::out_item_t pixel_q[$];
  logic [7:0]  img_bytes[$];
  bit          idle_en = 1'b1;
  int          fails = 0;
  int          cycles = 0;
  int          n_bytes = 0, n_pixels = 0, n_images = 0, n_ovf = 0;

  function automatic void clear_image();
    hdr = '0;
    byte_pos = 0;
    line_cnt = '0;
    low_hold = '0;
    seg_vis = 1'b0;
    row_stop = 1'b0;
    img_stop = 1'b0;
    first_seg = 1'b1;
    ovf_seen = 1'b0;
  endfunction

  function automatic int cur_row();
    int ls;
    ls = int'($signed(line_cnt));
    if (regs.flip_mode[1]) return int'(regs.img_height) - ls - 1;
    return ls;
  endfunction

  function automatic void start_segment();
    int r;
    if (first_seg) begin
      line_cnt = hdr[14] ? {1'b0, regs.first_line} : 13'h1FFF;
      first_seg = 1'b0;
    end
    if (!hdr[14]) line_cnt = line_cnt + 13'd1;
    seg_vis = 1'b0;
    row_stop = 1'b0;
    if (hdr[15] && hdr[31:16] > BufDepth) ovf_seen = 1'b1;
    if (img_stop) return;
    r = cur_row();
    if (regs.flip_mode[1]) begin
      if (r > int'(regs.clip_y_hi)) return;
      if (r < int'(regs.clip_y_lo)) begin
        img_stop = 1'b1;
        return;
      end
    end else begin
      if (r < int'(regs.clip_y_lo)) return;
      if (r > int'(regs.clip_y_hi)) begin
        img_stop = 1'b1;
        return;
      end
    end
    seg_vis = 1'b1;
  endfunction

  function automatic bit place_pixel(input int idx, output logic [11:0] px,
                                     output logic [11:0] py);
    int c;
    px = '0;
    py = '0;
    if (!seg_vis || row_stop || img_stop) return 1'b0;
    c = int'(hdr[11:0]) + idx;
    if (regs.flip_mode[0]) begin
      c = int'(regs.img_width) - c;
      if (c > int'(regs.clip_x_hi)) return 1'b0;
      if (c < int'(regs.clip_x_lo)) begin
        row_stop = 1'b1;
        return 1'b0;
      end
    end else begin
      if (c < int'(regs.clip_x_lo)) return 1'b0;
      if (c > int'(regs.clip_x_hi)) begin
        row_stop = 1'b1;
        return 1'b0;
      end
    end
    px = 12'(c - int'(regs.clip_x_lo));
    py = 12'(cur_row() - int'(regs.clip_y_lo));
    return 1'b1;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                     output ssld_pkg::out_item_t res);
    int pos, width, pix_end, alpha_end, k, idx, total;
    bit emit;
    logic [11:0] px, py;
    logic [15:0] c;
    pos = byte_pos;
    emit = 1'b0;
    res = '0;
    if (pos < 4) begin
      hdr = hdr | (32'(b) << (8 * pos));
      if (pos == 3) start_segment();
    end else begin
      width = int'(hdr[31:16]);
      pix_end = 4 + 2 * width;
      alpha_end = pix_end + (hdr[15] ? width : 0);
      if (pos < pix_end) begin
        k = pos - 4;
        idx = k >> 1;
        if (k % 2 == 0) begin
          low_hold = b;
        end else begin
          c = {b, low_hold};
          if (hdr[15]) begin
            if (idx < BufDepth) seg_buf[idx] = c;
          end else if (place_pixel(idx, px, py)) begin
            emit = 1'b1;
            res.pixel_x = px;
            res.pixel_y = py;
            res.color = c;
            res.alpha = ssld_pkg::AlphaOpaque;
          end
        end
      end else if (pos < alpha_end) begin
        idx = pos - pix_end;
        if (idx < BufDepth && place_pixel(idx, px, py)) begin
          emit = 1'b1;
          res.pixel_x = px;
          res.pixel_y = py;
          res.color = seg_buf[idx];
          res.alpha = b;
        end
      end
    end
    if (pos >= 3) begin
      total = 4 + (2 + int'(hdr[15])) * int'(hdr[31:16]) + int'(hdr[13:12]);
      if (pos + 1 >= total) begin
        byte_pos = 0;
        hdr = '0;
        row_stop = 1'b0;
      end else begin
        byte_pos = pos + 1;
      end
    end else begin
      byte_pos = pos + 1;
    end
    if (!emit && !last) return 1'b0;
    res.pixel_valid = emit;
    res.image_done = last;
    res.overflow = ovf_seen;
    if (last) clear_image();
    return 1'b1;
  endfunction

  // directed stream
  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         typed;
    ssld_pkg::out_item_t exp;
  } dir_row_t;

  localparam ssld_pkg::out_item_t NoPix = '{1'b0, 12'd0, 12'd0, 16'd0, 8'd0, 1'b1, 1'b0};

  dir_row_t dir_tab[18] = '{
    // plain segment, one pixel, origin
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h34, 1'b0, 1'b0, '0},
    '{8'h12, 1'b1, 1'b1, '{1'b1, 12'd0, 12'd0, 16'h1234, 8'd255, 1'b1, 1'b0}},
    // lone last byte
    '{8'hFF, 1'b1, 1'b1, NoPix},
    // keep-inline alpha segment, x 5, width 2, one pad byte
    '{8'h05, 1'b0, 1'b0, '0}, '{8'hD0, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hAB, 1'b1, 1'b1, NoPix}
  };

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("segmented_sprite_line_decoder: mismatch");
      $finish;
    end
  end

  function automatic void check_field(string name, int unsigned e, int unsigned a);
    if (e != a) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin
    ssld_pkg::out_item_t e, a;
    if (rst_ni && out_if.valid && out_if.ready) begin
      a = out_if.payload;
      if (pixel_q.size() == 0) begin
        $error("unexpected request: %p", a);
        fails++;
      end else begin
        e = pixel_q.pop_front();
        check_field("pixel_valid", e.pixel_valid, a.pixel_valid);
        check_field("pixel_x", e.pixel_x, a.pixel_x);
        check_field("pixel_y", e.pixel_y, a.pixel_y);
        check_field("color", e.color, a.color);
        check_field("alpha", e.alpha, a.alpha);
        check_field("image_done", e.image_done, a.image_done);
        check_field("overflow", e.overflow, a.overflow);
        if (a.pixel_valid) n_pixels++;
      end
    end
  end

  // output stall bursts
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input ssld_pkg::out_item_t exp);
    ssld_pkg::out_item_t res;
    if (n_bytes > IdleStop) idle_en = 1'b0;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= '{data_byte: b, last_byte: last};
    do @(posedge clk_i); while (!in_if.ready);
    n_bytes++;
    if (last) n_images++;
    if (decode_byte(b, last, res)) pixel_q.push_back(typed ? exp : res);
  endtask

  task automatic write_reg(input ssld_pkg::cfg_idx_e idx, input logic [11:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      ssld_pkg::CfgImgWidth:  regs.img_width = val;
      ssld_pkg::CfgImgHeight: regs.img_height = val;
      ssld_pkg::CfgFirstLine: regs.first_line = val;
      ssld_pkg::CfgClipXLo:   regs.clip_x_lo = val;
      ssld_pkg::CfgClipXHi:   regs.clip_x_hi = val;
      ssld_pkg::CfgClipYLo:   regs.clip_y_lo = val;
      ssld_pkg::CfgClipYHi:   regs.clip_y_hi = val;
      ssld_pkg::CfgFlipMode:  regs.flip_mode = val[1:0];
    endcase
  endtask

  task automatic load_setting(input ssld_pkg::cfg_t s);
    in_if.valid <= 1'b0;
    wait (pixel_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    write_reg(ssld_pkg::CfgImgWidth, s.img_width);
    write_reg(ssld_pkg::CfgImgHeight, s.img_height);
    write_reg(ssld_pkg::CfgFirstLine, s.first_line);
    write_reg(ssld_pkg::CfgClipXLo, s.clip_x_lo);
    write_reg(ssld_pkg::CfgClipXHi, s.clip_x_hi);
    write_reg(ssld_pkg::CfgClipYLo, s.clip_y_lo);
    write_reg(ssld_pkg::CfgClipYHi, s.clip_y_hi);
    write_reg(ssld_pkg::CfgFlipMode, 12'(s.flip_mode));
    cfg_we_i <= 1'b0;
  endtask

  function automatic ssld_pkg::cfg_t random_setting();
    ssld_pkg::cfg_t s;
    s.img_width = 12'($urandom_range(0, 60));
    s.img_height = 12'($urandom_range(0, 40));
    s.first_line = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, 12));
    s.clip_x_lo = 12'($urandom_range(0, 10));
    s.clip_x_hi = ($urandom_range(0, 7) == 0) ? 12'hFFF : s.clip_x_lo + 12'($urandom_range(0, 40));
    s.clip_y_lo = 12'($urandom_range(0, 4));
    s.clip_y_hi = ($urandom_range(0, 7) == 0) ? 12'hFFF : s.clip_y_lo + 12'($urandom_range(0, 12));
    s.flip_mode = 2'($urandom);
    return s;
  endfunction

  // an oversized segment is cut short: the image ends inside it
  task automatic add_segment(input bit oversized);
    int w, x, n_tail;
    logic [15:0] h;
    bit alpha;
    alpha = $urandom_range(0, 1);
    if (oversized) begin
      alpha = 1'b1;
      w = BufDepth + $urandom_range(1, 4);
      n_ovf++;
    end else begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    end
    x = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 40);
    h = {alpha, 1'($urandom), 2'($urandom), 12'(x)};
    img_bytes.push_back(h[7:0]);
    img_bytes.push_back(h[15:8]);
    img_bytes.push_back(8'(w));
    img_bytes.push_back(8'(w >> 8));
    if (oversized) n_tail = $urandom_range(1, 12);
    else n_tail = (2 + int'(alpha)) * w + int'(h[13:12]);
    repeat (n_tail) img_bytes.push_back(8'($urandom));
  endtask

  task automatic send_image(input bit want_ovf);
    int n, k;
    img_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 16)) img_bytes.push_back(8'($urandom));
    end else begin
      n = $urandom_range(1, 8);
      for (k = 0; k < n; k++) add_segment(want_ovf && k == n - 1);
      if (!want_ovf && $urandom_range(0, 9) == 0) begin
        k = $urandom_range(1, img_bytes.size());
        while (img_bytes.size() > k) void'(img_bytes.pop_back());
      end
    end
    foreach (img_bytes[i]) send_byte(img_bytes[i], i == img_bytes.size() - 1, 1'b0, '0);
  endtask

  initial begin
    ssld_pkg::cfg_t s;
    int phase;
    in_if.valid <= 1'b0;
    in_if.payload <= '0;
    regs = '{img_width: 12'd0, img_height: 12'd0, first_line: 12'd0, clip_x_lo: 12'd0,
             clip_x_hi: 12'hFFF, clip_y_lo: 12'd0, clip_y_hi: 12'hFFF, flip_mode: 2'd0};
    clear_image();
    foreach (seg_buf[i]) seg_buf[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_byte(dir_tab[i].b, dir_tab[i].last, dir_tab[i].typed,
                                   dir_tab[i].exp);

    for (phase = 0; n_bytes < ItemTarget; phase++) begin
      case (phase)
        0: s = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 2'd0};
        1: s = '{12'hFFF, 12'hFFF, 12'hFFF, 12'd0, 12'hFFF, 12'd0, 12'hFFF, 2'd3};
        2: s = '{12'd20, 12'd10, 12'd0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 2'd1};
        default: s = random_setting();
      endcase
      load_setting(s);
      repeat (3) begin
        if (n_bytes < ItemTarget) send_image($urandom_range(0, 5) == 0);
      end
    end
    in_if.valid <= 1'b0;
    wait (pixel_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    $display("sent %0d bytes in %0d images over %0d register settings", n_bytes, n_images,
             phase);
    $display("checked %0d pixel writes, %0d oversized alpha segments", n_pixels, n_ovf);
    if (fails == 0) begin
      $display("segmented_sprite_line_decoder: match");
    end else begin
      $display("segmented_sprite_line_decoder: mismatch");
    end
    $finish;
  end

endmodule
